@@ hw/rtl/quorum_response_voter_core_macros.svh @@
// Assertion macros shared by the quorum voter RTL.
`ifndef QUORUM_RESPONSE_VOTER_CORE_MACROS_SVH
`define QUORUM_RESPONSE_VOTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define QRV_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("qrv assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define QRV_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("qrv assertion failed");

`endif

@@ hw/rtl/qrv_pkg.sv @@
// Types and constants for the quorum response voter.
package qrv_pkg;

    localparam int EXP_W      = 4;
    localparam int CNT_W      = 4;
    localparam int CHK_W      = 32;
    localparam int TAG_W      = 16;
    localparam int OUTCOME_W  = 2;
    localparam int KEPT_SLOTS = 3;

    localparam int MAX_REPLICAS_DEF = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START,
        CMD_GOOD,
        CMD_ERROR
    } t_cmd_kind;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_PENDING,
        OUT_AGREED,
        OUT_NO_QUORUM,
        OUT_MISMATCH
    } t_outcome;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [EXP_W-1:0]   expected;
        logic [CNT_W-1:0]   quorum;
        logic [CHK_W-1:0]   checksum;
        logic [TAG_W-1:0]   tag;
    } t_cmd;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

@@ hw/rtl/qrv_if.sv @@
// Request and response channel interfaces of the quorum voter.
interface qrv_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [qrv_pkg::EXP_W-1:0]  expected_replies;
    logic                       err_flag;
    logic [qrv_pkg::CHK_W-1:0]  payload_checksum;
    logic [qrv_pkg::TAG_W-1:0]  reply_tag;

    modport source (
        output valid, action, expected_replies, err_flag, payload_checksum, reply_tag,
        input  ready
    );
    modport sink (
        input  valid, action, expected_replies, err_flag, payload_checksum, reply_tag,
        output ready
    );
endinterface

interface qrv_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          decided;
    logic [qrv_pkg::OUTCOME_W-1:0] outcome;
    logic [qrv_pkg::TAG_W-1:0]     chosen_tag;
    logic [qrv_pkg::CNT_W-1:0]     good_count;
    logic [qrv_pkg::CNT_W-1:0]     error_count;
    logic                          overflow;

    modport source (
        output valid, decided, outcome, chosen_tag, good_count, error_count, overflow,
        input  ready
    );
    modport sink (
        input  valid, decided, outcome, chosen_tag, good_count, error_count, overflow,
        output ready
    );
endinterface

@@ hw/rtl/quorum_response_voter_core.sv @@
// Quorum response voter top level: front end, command queue and vote engine.
//
// Usage:
//   i_req carries one beat per item: action 0 opens a request with an expected
//   replica count (0 taken as 1, capped at MAX_REPLICAS), action 1 submits a
//   reply with its error flag, payload checksum and tag.
//   o_rsp returns exactly one beat per request beat, in order: decided,
//   outcome, chosen tag, good and error counts, and the overflow flag.
// Timing:
//   An accepted beat is written into the queue, then applied by the vote engine
//   once its output slot is free, and its registered result shows on o_rsp.
//   One beat per cycle is sustained while o_rsp does not stall; the vote state
//   update (counters and three checksum compares) is combinational in the engine.
// Reset:
//   Synchronous, active low; clears the queue, the output valid and the vote
//   state, so a reply before any start reports overflow and pending.
// Backpressure:
//   While o_rsp stalls the engine holds its result and the two-entry queue
//   keeps taking beats; i_req.ready drops only when the queue is full.
`include "quorum_response_voter_core_macros.svh"

module quorum_response_voter_core #(
    parameter int MAX_REPLICAS = qrv_pkg::MAX_REPLICAS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrv_req_if.sink     i_req,
    qrv_rsp_if.source   o_rsp
);

    logic              q_push;
    logic              q_pop;
    qrv_pkg::t_cmd     q_in;
    qrv_pkg::t_cmd     q_head;
    qrv_pkg::t_q_stat  q_stat;

    qrv_front #(
        .MAX_REPLICAS (MAX_REPLICAS)
    ) u_front (
        .i_req  (i_req),
        .i_full (q_stat.full),
        .o_push (q_push),
        .o_cmd  (q_in)
    );

    qrv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    qrv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_stat  (q_stat),
        .o_pop   (q_pop),
        .o_rsp   (o_rsp)
    );

    // queue never holds more than its depth
    `QRV_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= qrv_pkg::QUEUE_DEPTH)
    // a queued command with a free output slot produces a result beat next cycle
    `QRV_ASSERT_NEXT(a_drain, !q_stat.empty && (!o_rsp.valid || o_rsp.ready), o_rsp.valid)
    // agreement needs at least one good reply
    `QRV_ASSERT_NOW(a_agree_good, o_rsp.valid && (o_rsp.outcome == qrv_pkg::OUT_AGREED), o_rsp.good_count != '0)
    // quorum can only be lost through error replies
    `QRV_ASSERT_NOW(a_noq_err, o_rsp.valid && (o_rsp.outcome == qrv_pkg::OUT_NO_QUORUM), o_rsp.error_count != '0)

endmodule

@@ hw/rtl/qrv_front.sv @@
// Front end: takes request beats and classifies them into voter commands.
module qrv_front #(
    parameter int MAX_REPLICAS = qrv_pkg::MAX_REPLICAS_DEF
) (
    qrv_req_if.sink        i_req,
    input  logic           i_full,
    output logic           o_push,
    output qrv_pkg::t_cmd  o_cmd
);

    localparam logic [qrv_pkg::EXP_W-1:0] MaxExp = qrv_pkg::EXP_W'(MAX_REPLICAS);

    logic [qrv_pkg::EXP_W-1:0] exp_sat;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        // zero means one replica, anything above the limit saturates
        if (i_req.expected_replies == '0) begin
            exp_sat = qrv_pkg::EXP_W'(1);
        end else if (i_req.expected_replies > MaxExp) begin
            exp_sat = MaxExp;
        end else begin
            exp_sat = i_req.expected_replies;
        end

        if (!i_req.action) begin
            o_cmd.kind = qrv_pkg::CMD_START;
        end else if (i_req.err_flag) begin
            o_cmd.kind = qrv_pkg::CMD_ERROR;
        end else begin
            o_cmd.kind = qrv_pkg::CMD_GOOD;
        end
        o_cmd.expected = exp_sat;
        o_cmd.quorum   = qrv_pkg::CNT_W'(exp_sat >> 1) + qrv_pkg::CNT_W'(1);
        o_cmd.checksum = i_req.payload_checksum;
        o_cmd.tag      = i_req.reply_tag;
    end

endmodule

@@ hw/rtl/qrv_queue.sv @@
// Short command queue between the front end and the vote engine.
module qrv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qrv_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output qrv_pkg::t_cmd     o_head,
    output qrv_pkg::t_q_stat  o_stat
);

    localparam int Depth = qrv_pkg::QUEUE_DEPTH;
    localparam logic [qrv_pkg::QPTR_W-1:0] LastPtr = qrv_pkg::QPTR_W'(Depth - 1);
    localparam logic [qrv_pkg::QCNT_W-1:0] FullCnt = qrv_pkg::QCNT_W'(Depth);

    qrv_pkg::t_cmd               r_mem [Depth];
    logic [qrv_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [qrv_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [qrv_pkg::QCNT_W-1:0]  r_count;
    logic [qrv_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [qrv_pkg::QPTR_W-1:0]  n_rd_ptr;
    logic [qrv_pkg::QCNT_W-1:0]  n_count;
    logic                        do_push;
    logic                        do_pop;

    assign do_push = i_push && (r_count != FullCnt);
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FullCnt);
    assign o_stat.count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + qrv_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + qrv_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + qrv_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - qrv_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/qrv_back.sv @@
// Vote engine: applies commands to the vote state and registers each result beat.
module qrv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qrv_pkg::t_cmd     i_head,
    input  qrv_pkg::t_q_stat  i_stat,
    output logic              o_pop,
    qrv_rsp_if.source         o_rsp
);

    localparam int SumW = qrv_pkg::CNT_W + 1;
    localparam int CntW = qrv_pkg::CNT_W;

    logic [qrv_pkg::EXP_W-1:0]  r_expected;
    logic [CntW-1:0]            r_quorum;
    logic [CntW-1:0]            r_good;
    logic [CntW-1:0]            r_error;
    logic                       r_have_err;
    logic [qrv_pkg::TAG_W-1:0]  r_first_err_tag;
    logic [qrv_pkg::CHK_W-1:0]  r_chk [qrv_pkg::KEPT_SLOTS];
    logic [qrv_pkg::TAG_W-1:0]  r_tag [qrv_pkg::KEPT_SLOTS];

    logic                       r_valid;
    logic                       r_decided;
    qrv_pkg::t_outcome          r_outcome;
    logic [qrv_pkg::TAG_W-1:0]  r_chosen;
    logic                       r_overflow;

    logic [qrv_pkg::EXP_W-1:0]  n_expected;
    logic [CntW-1:0]            n_quorum;
    logic [CntW-1:0]            n_good;
    logic [CntW-1:0]            n_error;
    logic                       n_have_err;
    logic [qrv_pkg::TAG_W-1:0]  n_first_err_tag;
    logic [qrv_pkg::CHK_W-1:0]  n_chk [qrv_pkg::KEPT_SLOTS];
    logic [qrv_pkg::TAG_W-1:0]  n_tag [qrv_pkg::KEPT_SLOTS];
    qrv_pkg::t_outcome          n_outcome;
    logic [qrv_pkg::TAG_W-1:0]  n_chosen;
    logic                       n_overflow;

    logic                       full_up;
    logic                       agree;
    logic [qrv_pkg::TAG_W-1:0]  agree_tag;
    logic [SumW-1:0]            seen;
    logic [SumW-1:0]            exp_w;

    assign o_pop = !i_stat.empty && (!r_valid || o_rsp.ready);

    assign full_up = ({1'b0, r_good} + {1'b0, r_error}) >= {{(SumW - qrv_pkg::EXP_W){1'b0}},
                                                             r_expected};

    always_comb begin
        n_expected      = r_expected;
        n_quorum        = r_quorum;
        n_good          = r_good;
        n_error         = r_error;
        n_have_err      = r_have_err;
        n_first_err_tag = r_first_err_tag;
        n_overflow      = 1'b0;
        for (int i = 0; i < qrv_pkg::KEPT_SLOTS; i++) begin
            n_chk[i] = r_chk[i];
            n_tag[i] = r_tag[i];
        end

        case (i_head.kind)
            qrv_pkg::CMD_START: begin
                n_expected = i_head.expected;
                n_quorum   = i_head.quorum;
                n_good     = '0;
                n_error    = '0;
                n_have_err = 1'b0;
            end
            qrv_pkg::CMD_ERROR: begin
                if (full_up) begin
                    n_overflow = 1'b1;
                end else begin
                    if (!r_have_err) begin
                        n_have_err      = 1'b1;
                        n_first_err_tag = i_head.tag;
                    end
                    n_error = r_error + CntW'(1);
                end
            end
            qrv_pkg::CMD_GOOD: begin
                if (full_up) begin
                    n_overflow = 1'b1;
                end else begin
                    for (int i = 0; i < qrv_pkg::KEPT_SLOTS; i++) begin
                        if (r_good == CntW'(i)) begin
                            n_chk[i] = i_head.checksum;
                            n_tag[i] = i_head.tag;
                        end
                    end
                    n_good = r_good + CntW'(1);
                end
            end
            default: begin
                n_overflow = 1'b0;
            end
        endcase

        // agreement search on the updated slots; slot 2 only once three goods are in
        agree     = 1'b0;
        agree_tag = n_tag[0];
        if (n_quorum == CntW'(1) && n_good == CntW'(1)) begin
            agree = 1'b1;
        end else if (n_good >= n_quorum && n_good >= CntW'(2)) begin
            if (n_chk[0] == n_chk[1]) begin
                agree = 1'b1;
            end else if (n_good >= CntW'(3)) begin
                if (n_chk[1] == n_chk[2]) begin
                    agree     = 1'b1;
                    agree_tag = n_tag[1];
                end else if (n_chk[0] == n_chk[2]) begin
                    agree = 1'b1;
                end
            end
        end

        seen  = {1'b0, n_good} + {1'b0, n_error};
        exp_w = {{(SumW - qrv_pkg::EXP_W){1'b0}}, n_expected};

        n_outcome = qrv_pkg::OUT_PENDING;
        n_chosen  = '0;
        if (n_expected != '0) begin
            if (n_good >= n_quorum) begin
                if (agree) begin
                    n_outcome = qrv_pkg::OUT_AGREED;
                    n_chosen  = agree_tag;
                end else if (seen == exp_w) begin
                    n_outcome = qrv_pkg::OUT_MISMATCH;
                end
            end else if ((exp_w - {1'b0, n_error}) < {1'b0, n_quorum}) begin
                // even every outstanding reply good would fall short
                n_outcome = qrv_pkg::OUT_NO_QUORUM;
                n_chosen  = n_have_err ? n_first_err_tag : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_quorum   <= '0;
            r_good     <= '0;
            r_error    <= '0;
            r_have_err <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_expected <= n_expected;
                r_quorum   <= n_quorum;
                r_good     <= n_good;
                r_error    <= n_error;
                r_have_err <= n_have_err;
                r_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first_err_tag <= n_first_err_tag;
            for (int i = 0; i < qrv_pkg::KEPT_SLOTS; i++) begin
                r_chk[i] <= n_chk[i];
                r_tag[i] <= n_tag[i];
            end
            r_decided  <= (n_outcome != qrv_pkg::OUT_PENDING);
            r_outcome  <= n_outcome;
            r_chosen   <= n_chosen;
            r_overflow <= n_overflow;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.decided     = r_decided;
    assign o_rsp.outcome     = r_outcome;
    assign o_rsp.chosen_tag  = r_chosen;
    assign o_rsp.good_count  = r_good;
    assign o_rsp.error_count = r_error;
    assign o_rsp.overflow    = r_overflow;

endmodule

@@ dv/qrv_tb_pkg.sv @@
`timescale 1ns / 1ps
// Beat type and action codes shared by the quorum voter testbench.
package qrv_tb_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [qrv_pkg::EXP_W-1:0] expected;
        logic                      err_flag;
        logic [qrv_pkg::CHK_W-1:0] checksum;
        logic [qrv_pkg::TAG_W-1:0] tag;
    } t_reply_beat;

endpackage

@@ dv/qrv_vote_checker.sv @@
`timescale 1ns / 1ps
// Vote checker: tracks accepted request beats, predicts each response and compares.
module qrv_vote_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    qrv_req_if   i_req,
    qrv_rsp_if   i_rsp,
    output int   o_fail_cnt,
    output int   o_owed_cnt
);
    import qrv_pkg::*;
    import qrv_tb_pkg::*;

    localparam int REPLICA_CAP = MAX_REPLICAS_DEF;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic             decided;
        t_outcome         outcome;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] good;
        logic [CNT_W-1:0] errs;
        logic             overflow;
    } t_verdict;

    int unsigned      exp_replies;
    int unsigned      quorum;
    int unsigned      good_seen;
    int unsigned      errs_seen;
    logic [CHK_W-1:0] kept_sum [KEPT_SLOTS];
    logic [TAG_W-1:0] kept_tag [KEPT_SLOTS];
    logic [TAG_W-1:0] first_err_tag;
    logic             err_seen;
    t_verdict         owed_verdicts [$];
    int               fail_cnt = 0;

    function automatic void clear_vote();
        exp_replies   = 0;
        quorum        = 0;
        good_seen     = 0;
        errs_seen     = 0;
        first_err_tag = '0;
        err_seen      = 1'b0;
        for (int i = 0; i < KEPT_SLOTS; i++) begin
            kept_sum[i] = '0;
            kept_tag[i] = '0;
        end
    endfunction

    // Pair order: slots 0/1, then 1/2, then 0/2
    function automatic logic find_pair(output logic [TAG_W-1:0] tag);
        tag = '0;
        if (quorum == 1 && good_seen == 1) begin
            tag = kept_tag[0];
            return 1'b1;
        end
        if (good_seen < quorum || good_seen < 2)
            return 1'b0;
        if (kept_sum[0] == kept_sum[1]) begin
            tag = kept_tag[0];
            return 1'b1;
        end
        if (good_seen < 3)
            return 1'b0;
        if (kept_sum[1] == kept_sum[2]) begin
            tag = kept_tag[1];
            return 1'b1;
        end
        if (kept_sum[0] == kept_sum[2]) begin
            tag = kept_tag[0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_verdict tally_vote(t_reply_beat b);
        t_verdict         v;
        int unsigned      e;
        int unsigned      left;
        logic [TAG_W-1:0] pick;
        v.overflow = 1'b0;
        v.outcome  = OUT_PENDING;
        v.tag      = '0;
        if (b.action == ACT_START) begin
            e = b.expected;
            if (e == 0)
                e = 1;
            if (e > REPLICA_CAP)
                e = REPLICA_CAP;
            clear_vote();
            exp_replies = e;
            quorum      = e / 2 + 1;
        end else if (good_seen + errs_seen >= exp_replies) begin
            v.overflow = 1'b1;
        end else if (b.err_flag) begin
            if (!err_seen) begin
                err_seen      = 1'b1;
                first_err_tag = b.tag;
            end
            errs_seen++;
        end else begin
            if (good_seen < KEPT_SLOTS) begin
                kept_sum[good_seen] = b.checksum;
                kept_tag[good_seen] = b.tag;
            end
            good_seen++;
        end
        if (exp_replies != 0) begin
            left = exp_replies - good_seen - errs_seen;
            if (good_seen >= quorum) begin
                if (find_pair(pick)) begin
                    v.outcome = OUT_AGREED;
                    v.tag     = pick;
                end else if (left == 0) begin
                    v.outcome = OUT_MISMATCH;
                end
            end else if (left + good_seen < quorum) begin
                v.outcome = OUT_NO_QUORUM;
                v.tag     = err_seen ? first_err_tag : '0;
            end
        end
        v.decided = (v.outcome != OUT_PENDING);
        v.good    = good_seen[CNT_W-1:0];
        v.errs    = errs_seen[CNT_W-1:0];
        return v;
    endfunction

    task automatic note_fault(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_verdict    want;
        t_reply_beat b;
        if (!i_rst_n) begin
            clear_vote();
            owed_verdicts.delete();
        end else begin
            // a response at this edge belongs to an earlier request beat
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_verdicts.size() == 0) begin
                    note_fault("response beat with no request outstanding");
                end else begin
                    want = owed_verdicts.pop_front();
                    if (i_rsp.decided !== want.decided || i_rsp.outcome !== want.outcome ||
                        i_rsp.chosen_tag !== want.tag || i_rsp.good_count !== want.good ||
                        i_rsp.error_count !== want.errs || i_rsp.overflow !== want.overflow)
                        note_fault($sformatf({"response differs: want dec=%0b out=%0d tag=%h ",
                            "good=%0d err=%0d ovf=%0b, got dec=%0b out=%0d tag=%h ",
                            "good=%0d err=%0d ovf=%0b"},
                            want.decided, want.outcome, want.tag, want.good, want.errs,
                            want.overflow, i_rsp.decided, i_rsp.outcome, i_rsp.chosen_tag,
                            i_rsp.good_count, i_rsp.error_count, i_rsp.overflow));
                end
            end
            if (i_req.valid && i_req.ready) begin
                b.action   = i_req.action;
                b.expected = i_req.expected_replies;
                b.err_flag = i_req.err_flag;
                b.checksum = i_req.payload_checksum;
                b.tag      = i_req.reply_tag;
                owed_verdicts.push_back(tally_vote(b));
            end
        end
        o_fail_cnt <= fail_cnt;
        o_owed_cnt <= owed_verdicts.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and response traffic, and the verdict.
module tb;
    import qrv_pkg::*;
    import qrv_tb_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 60;
    localparam int PHASE_BEATS  = 228;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   owed_cnt;
    int   tx_idle_pct = 0;
    int   rx_idle_pct;
    int   phase;
    int   held_phase = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    qrv_req_if req_ch();
    qrv_rsp_if rsp_ch();

    quorum_response_voter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    qrv_vote_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_fail_cnt (fail_cnt),
        .o_owed_cnt (owed_cnt)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver: one long hold at the start of each random phase, else random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (phase != held_phase) begin
                hold_left  = LONG_HOLD;
                held_phase = phase;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_reply_beat start_beat(logic [EXP_W-1:0] e);
        t_reply_beat b;
        b.action   = ACT_START;
        b.expected = e;
        b.err_flag = 1'($urandom_range(1));
        b.checksum = $urandom;
        b.tag      = TAG_W'($urandom);
        return b;
    endfunction

    function automatic t_reply_beat reply_beat(logic is_err, logic [CHK_W-1:0] chk,
                                               logic [TAG_W-1:0] tag);
        t_reply_beat b;
        b.action   = ACT_REPLY;
        b.expected = EXP_W'($urandom_range(15));
        b.err_flag = is_err;
        b.checksum = chk;
        b.tag      = tag;
        return b;
    endfunction

    task automatic push_beat(input t_reply_beat b);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.action           <= b.action;
        req_ch.expected_replies <= b.expected;
        req_ch.err_flag         <= b.err_flag;
        req_ch.payload_checksum <= b.checksum;
        req_ch.reply_tag        <= b.tag;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // Mostly whole requests with a few overflowing or cut short; some raw noise beats
    task automatic run_requests(input int n_beats);
        int               sent;
        int               e;
        int               eff;
        int               n;
        int               err_pct;
        int               r;
        logic [CHK_W-1:0] pool [3];
        logic [CHK_W-1:0] chk;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(99) < 8) begin
                push_beat(reply_beat(1'($urandom_range(1)), $urandom, TAG_W'($urandom)));
                if ($urandom_range(1))
                    push_beat(start_beat(EXP_W'($urandom_range(15))));
                sent += 1;
            end else begin
                e   = ($urandom_range(99) < 10) ? $urandom_range(15) : $urandom_range(1, 8);
                eff = (e == 0) ? 1 : ((e > MAX_REPLICAS_DEF) ? MAX_REPLICAS_DEF : e);
                n   = eff + $urandom_range(2);
                if ($urandom_range(99) < 15)
                    n = $urandom_range(eff);
                err_pct = $urandom_range(50);
                for (int i = 0; i < 3; i++)
                    pool[i] = $urandom;
                push_beat(start_beat(EXP_W'(e)));
                sent++;
                for (int i = 0; i < n; i++) begin
                    r   = $urandom_range(99);
                    chk = (r < 45) ? pool[0] : (r < 80) ? pool[1] : (r < 92) ? pool[2] : $urandom;
                    push_beat(reply_beat($urandom_range(99) < err_pct, chk, TAG_W'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.action           <= ACT_START;
        req_ch.expected_replies <= '0;
        req_ch.err_flag         <= 1'b0;
        req_ch.payload_checksum <= '0;
        req_ch.reply_tag        <= '0;
        phase                   <= 0;
        rx_idle_pct             <= 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // replies ahead of any start are dropped as overflow
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'hFFFF));
        push_beat(reply_beat(1'b1, 32'h0000_0000, 16'h0000));
        // zero count taken as one: a single good reply agrees, the next overflows
        push_beat(start_beat(4'd0));
        push_beat(reply_beat(1'b0, 32'h0000_0000, 16'h0001));
        push_beat(reply_beat(1'b0, 32'h1234_5678, 16'h0002));
        // count saturates at the cap; errors alone make quorum unreachable
        push_beat(start_beat(4'd15));
        push_beat(reply_beat(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        push_beat(reply_beat(1'b1, 32'h0000_0000, 16'h1234));
        push_beat(reply_beat(1'b1, 32'h0000_0000, 16'h5555));
        push_beat(reply_beat(1'b1, 32'h0000_0000, 16'hAAAA));
        // agreement on slots 1 and 2
        push_beat(start_beat(4'd3));
        push_beat(reply_beat(1'b0, 32'h0000_0000, 16'h0011));
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'h0012));
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'h0013));
        // agreement on slots 0 and 2
        push_beat(start_beat(4'd3));
        push_beat(reply_beat(1'b0, 32'h0000_0000, 16'h0021));
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'h0022));
        push_beat(reply_beat(1'b0, 32'h0000_0000, 16'h0023));
        // three different checksums: mismatch
        push_beat(start_beat(4'd3));
        push_beat(reply_beat(1'b0, 32'h0000_0000, 16'h0031));
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'h0032));
        push_beat(reply_beat(1'b0, 32'h8000_0001, 16'h0033));
        // decision holds while later replies are still counted
        push_beat(start_beat(4'd2));
        push_beat(reply_beat(1'b1, 32'hFFFF_FFFF, 16'h00FF));
        push_beat(reply_beat(1'b0, 32'hFFFF_FFFF, 16'hFF00));

        phase       <= 1;
        tx_idle_pct  = 6;
        rx_idle_pct <= 69;
        run_requests(PHASE_BEATS);
        phase       <= 2;
        tx_idle_pct  = 69;
        rx_idle_pct <= 6;
        run_requests(PHASE_BEATS);
        phase       <= 3;
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        run_requests(PHASE_BEATS);
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (owed_cnt != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && owed_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/qrv_pkg.sv
hw/rtl/qrv_if.sv
hw/rtl/qrv_front.sv
hw/rtl/qrv_queue.sv
hw/rtl/qrv_back.sv
hw/rtl/quorum_response_voter_core.sv
dv/qrv_tb_pkg.sv
dv/qrv_vote_checker.sv
dv/tb.sv
